[src/ascii_integer_parser_defines.svh]
// Assertion macros for the ASCII integer parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define AIP_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("aip: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define AIP_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("aip: next-cycle check failed");
`else
`define AIP_ASSERT_IMPL(label, clk, rst, pre, post)
`define AIP_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[src/aip_pkg.sv]
// Shared types, character codes, parse phase codes and the digit decoder
// for the ASCII integer parser. No dependencies.
`default_nettype none

package aip_pkg;

  localparam int unsigned PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SIGNED = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ZERO0  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ZERO16 = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_DEC = 6'd10;
  localparam logic [5:0] BASE_HEX = 6'd16;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } held_t;

  typedef struct packed {
    logic        emit;
    logic [63:0] value;
    logic [15:0] offset;
    logic [5:0]  base;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } digit_t;

  // Digit value of a character: 0..9 and letters 10..35, ok low otherwise.
  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d.val = 6'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d.val = 6'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d.val = 6'(c - CH_UA + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[src/aip_in_reg.sv]
// Input register of the ASCII integer parser: holds one accepted transaction.
// Depends on aip_pkg.
`default_nettype none

module aip_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire aip_pkg::item_t in_item,
  input  wire logic          fire,
  output aip_pkg::held_t     held
);
  import aip_pkg::*;

  logic  full;
  item_t item;
  logic  accept;

  assign in_stall = full && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (fire) begin
      full <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

  assign held.valid = full;
  assign held.item  = item;

endmodule

`default_nettype wire

[src/aip_core.sv]
// Parse state and combinational step logic of the ASCII integer parser.
// Depends on aip_pkg and ascii_integer_parser_defines.svh.
`default_nettype none
`include "ascii_integer_parser_defines.svh"

module aip_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire aip_pkg::item_t item,
  input  wire logic [5:0]     base_mode,
  input  wire logic [15:0]    pos_cap,
  output aip_pkg::result_t    res
);
  import aip_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic               minus, minus_next;
  logic [5:0]         abase, abase_next;
  logic [63:0]        acc, acc_next;
  logic [15:0]        pos, pos_next;

  // Values after a string start has been applied.
  logic [PHASE_W-1:0] ph_s;
  logic               m_s;
  logic [5:0]         ab_s;
  logic [63:0]        acc_s;
  logic [15:0]        pos_s;

  logic               take;
  logic               is_blank;
  logic               is_x;
  logic [7:0]         c;
  digit_t             dig;
  logic               dig_ok;

  assign c        = item.char_code;
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  assign is_x     = (c == CH_LX) || (c == CH_UX);
  assign dig      = digit_of(c);

  always_comb begin
    ph_s  = item.string_start ? PH_LEAD : phase;
    m_s   = item.string_start ? 1'b0 : minus;
    ab_s  = item.string_start ? 6'd0 : abase;
    acc_s = item.string_start ? 64'd0 : acc;
    pos_s = item.string_start ? 16'd0 : pos;

    phase_next = ph_s;
    minus_next = m_s;
    abase_next = ab_s;
    take       = 1'b0;

    unique case (ph_s)
      PH_LEAD, PH_SIGNED: begin
        if (ph_s == PH_LEAD && is_blank) begin
          phase_next = PH_LEAD;
        end else if (ph_s == PH_LEAD && c == CH_MINUS) begin
          minus_next = 1'b1;
          phase_next = PH_SIGNED;
        end else if (ph_s == PH_LEAD && c == CH_PLUS) begin
          phase_next = PH_SIGNED;
        end else if (base_mode == 6'd0) begin
          if (c == CH_0) begin
            phase_next = PH_ZERO0;
          end else begin
            abase_next = BASE_DEC;
            phase_next = PH_DIGITS;
            take       = 1'b1;
          end
        end else if (base_mode == BASE_HEX) begin
          abase_next = BASE_HEX;
          if (c == CH_0) begin
            phase_next = PH_ZERO16;
          end else begin
            phase_next = PH_DIGITS;
            take       = 1'b1;
          end
        end else begin
          abase_next = base_mode;
          phase_next = PH_DIGITS;
          take       = 1'b1;
        end
      end
      PH_ZERO0: begin
        phase_next = PH_DIGITS;
        if (is_x) begin
          abase_next = BASE_HEX;
        end else begin
          abase_next = BASE_OCT;
          take       = 1'b1;
        end
      end
      PH_ZERO16: begin
        phase_next = PH_DIGITS;
        take       = !is_x;
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    // A character outside the base ends the number.
    dig_ok     = dig.ok && (dig.val < abase_next);
    acc_next   = acc_s;
    res.emit   = 1'b0;
    res.value  = m_s ? (64'd0 - acc_s) : acc_s;
    res.offset = pos_s;
    res.base   = abase_next;
    if (take) begin
      if (dig_ok) begin
        acc_next = acc_s * {58'd0, abase_next} + {58'd0, dig.val};
      end else begin
        res.emit   = 1'b1;
        phase_next = PH_DONE;
      end
    end

    pos_next = (pos_s < pos_cap) ? pos_s + 16'd1 : pos_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DONE;
      minus <= 1'b0;
      abase <= '0;
      acc   <= '0;
      pos   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      minus <= minus_next;
      abase <= abase_next;
      acc   <= acc_next;
      pos   <= pos_next;
    end
  end

  `AIP_ASSERT_NEXT(a_done_after_emit, clk, rst, fire && res.emit, phase == PH_DONE)

endmodule

`default_nettype wire

[src/ascii_integer_parser.sv]
// ASCII integer parser: turns a character stream into unsigned 64-bit
// integers, one character per transaction, with base selection from a register.
// Depends on aip_pkg, aip_in_reg, aip_core and ascii_integer_parser_defines.svh.
//
// One character enters per clock cycle, sustained, as long as the result side
// does not stall; the result of a string is loaded into the result register
// when the transaction carrying its terminating character leaves the input
// register through the step stage. The character rate is set by the single step
// stage between the input register and the result register, where the 64-bit
// accumulator takes one multiply by the 6-bit base plus a digit. While a finished
// result waits in the result register, one more character is accepted into the
// input register; after that the input stalls until the result is taken.
// Leading blanks, one sign and, in base 16 or base detection mode (base_mode 0),
// a 0x/0X prefix are consumed; the first character that is not a digit of the
// active base, NUL included, emits the value (negated on a minus sign), the stop
// offset and the base used. Strings without string_start are dropped silently,
// and a string start in mid-string abandons the old string with no result. The
// offset saturates at MAX_STRING_LEN or 65535, whichever is smaller. Write
// base_mode only while the block is idle.
`default_nettype none
`include "ascii_integer_parser_defines.svh"

module ascii_integer_parser #(
  parameter longint unsigned MAX_STRING_LEN = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [5:0]  base_mode,
  // character input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        string_start,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      parsed_value,
  output logic [15:0]      stop_offset,
  output logic [5:0]       base_used
);
  import aip_pkg::*;

  // Saturation point of the position counter.
  localparam logic [15:0] POS_CAP =
    (MAX_STRING_LEN > 64'd65535) ? 16'hFFFF : 16'(MAX_STRING_LEN);

  logic [5:0] base_reg;
  item_t      in_item;
  held_t      held;
  result_t    res;
  logic       fire;

  // Hold the base register; new strings pick up the written value.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= BASE_DEC;
    end else if (cfg_we) begin
      base_reg <= base_mode;
    end
  end

  assign in_item.char_code    = char_code;
  assign in_item.string_start = string_start;

  aip_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .fire     (fire),
    .held     (held)
  );

  // Advance the step stage whenever the result register can take a transaction
  // this cycle, whether or not this character produces one.
  assign fire = held.valid && (!out_valid || !out_stall);

  aip_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (held.item),
    .base_mode (base_reg),
    .pos_cap   (POS_CAP),
    .res       (res)
  );

  // Result register: load on an emitting step, drop once taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      parsed_value <= res.value;
      stop_offset  <= res.offset;
      base_used    <= res.base;
    end
  end

  `AIP_ASSERT_NEXT(a_emit_loads_result, clk, rst, fire && res.emit, out_valid)
  `AIP_ASSERT_IMPL(a_base_nonzero, clk, rst, out_valid, base_used != 6'd0)
  `AIP_ASSERT_IMPL(a_no_fire_when_blocked, clk, rst, out_valid && out_stall, !fire)

endmodule

`default_nettype wire

[tb/tb_ascii_integer_parser.sv]
// Self-checking testbench for ascii_integer_parser: directed character strings, then random
// strings across several base settings, checked against a behavioral parser held in this file.
// Depends on aip_pkg and the ascii_integer_parser RTL only.
`timescale 1ns / 100ps

module tb_ascii_integer_parser;
  import aip_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 6;     // margin for characters that close no string to leave the pipeline
  localparam int TAIL_CYCLES    = 12;
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off to back up the pipeline
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 70;    // with the directed rows, about 750 characters in all

  localparam longint unsigned MAX_LEN = 65535;
  localparam logic [15:0] POS_CAP = (MAX_LEN > 65535) ? 16'hFFFF : 16'(MAX_LEN);

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [5:0] BASE_DETECT = 6'd0;

  // base settings walked by the random part, extremes included; phase 9 is drawn at random
  localparam logic [8:0][5:0] PHASE_MODES = {
    BASE_DETECT, 6'd1, 6'd63, BASE_OCT, 6'd2, 6'd36, BASE_HEX, BASE_DEC, BASE_DETECT
  };
  localparam logic [3:0][7:0] BLANKS = {CH_SPACE, CH_TAB, CH_LF, CH_CR};

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] offset;
    logic [5:0]  base;
  } int_result_t;

  // one character of the directed table; a typed row carries its result written out by hand
  typedef struct packed {
    logic [5:0]  mode;
    logic [7:0]  ch;
    logic        st;
    logic        typed;
    int_result_t res;
  } stim_row_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  logic [5:0]  base_mode    = BASE_DEC;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code    = CH_NUL;
  logic        string_start = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [63:0] parsed_value;
  logic [15:0] stop_offset;
  logic [5:0]  base_used;

  int_result_t expected_results[$];
  stim_row_t   stim_rows[$];
  int          error_count  = 0;
  int          idle_cycles  = 0;
  bit          no_idle      = 1'b0;
  bit          hold_request = 1'b0;

  // parser state as the testbench sees it
  logic [5:0]         base_setting = BASE_DEC;
  logic [PHASE_W-1:0] scan_phase   = PH_DONE;
  bit                 saw_minus    = 1'b0;
  logic [5:0]         radix        = '0;
  logic [63:0]        accum        = '0;
  logic [15:0]        char_idx     = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ascii_integer_parser #(
    .MAX_STRING_LEN(MAX_LEN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .base_mode   (base_mode),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .string_start(string_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .parsed_value(parsed_value),
    .stop_offset (stop_offset),
    .base_used   (base_used)
  );

  // ---------------------------------------------------------------------------
  // Behavioral parser
  // ---------------------------------------------------------------------------

  // Digit weight of a byte, -1 when it is neither a decimal digit nor a letter.
  function automatic int char_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  // Fold one digit into the accumulator, or close the string on anything that is not a
  // digit of the active base (NUL included) and report value, offset and base.
  task automatic take_digit(input logic [7:0] c, output bit done, output int_result_t r);
    int d;
    d    = char_digit(c);
    done = 1'b0;
    r    = '0;
    if (c == CH_NUL || d < 0 || d >= int'(radix)) begin
      r.value    = saw_minus ? 64'd0 - accum : accum;
      r.offset   = char_idx;
      r.base     = radix;
      scan_phase = PH_DONE;
      done       = 1'b1;
    end else begin
      accum = accum * 64'(radix) + 64'(d);
    end
  endtask

  // First character after blanks and sign: settle the base. In detect mode a leading zero
  // defers the choice to the next byte; in base 16 a leading zero may open a 0x prefix.
  task automatic pick_base(input logic [7:0] c, output bit done, output int_result_t r);
    done = 1'b0;
    r    = '0;
    if (base_setting == BASE_DETECT && c == CH_0) begin
      scan_phase = PH_ZERO0;
    end else if (base_setting == BASE_HEX && c == CH_0) begin
      radix      = BASE_HEX;
      scan_phase = PH_ZERO16;
    end else begin
      radix      = (base_setting == BASE_DETECT) ? BASE_DEC : base_setting;
      scan_phase = PH_DIGITS;
      take_digit(c, done, r);
    end
  endtask

  // Advance the parser by one accepted character.
  task automatic predict_char(input logic [7:0] c, input logic st,
                              output bit done, output int_result_t r);
    done = 1'b0;
    r    = '0;
    if (st) begin
      // a string start always restarts, abandoning any string in progress
      scan_phase = PH_LEAD;
      saw_minus  = 1'b0;
      radix      = '0;
      accum      = '0;
      char_idx   = '0;
    end
    case (scan_phase)
      PH_LEAD: begin
        if (c == CH_MINUS) begin
          saw_minus  = 1'b1;
          scan_phase = PH_SIGNED;
        end else if (c == CH_PLUS) begin
          scan_phase = PH_SIGNED;
        end else if (c != CH_SPACE && c != CH_TAB && c != CH_LF && c != CH_CR) begin
          pick_base(c, done, r);
        end
      end
      PH_SIGNED: pick_base(c, done, r);
      PH_ZERO0: begin
        scan_phase = PH_DIGITS;
        if (c == CH_LX || c == CH_UX) begin
          radix = BASE_HEX;
        end else begin
          // lone zero in detect mode: octal, and this byte is already checked as an octal digit
          radix = BASE_OCT;
          take_digit(c, done, r);
        end
      end
      PH_ZERO16: begin
        scan_phase = PH_DIGITS;
        if (c != CH_LX && c != CH_UX) take_digit(c, done, r);
      end
      PH_DIGITS: take_digit(c, done, r);
      default: scan_phase = PH_DONE;  // done: drop bytes until the next string start
    endcase
    if (char_idx < POS_CAP) char_idx++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one character after a random gap and hold it until accepted, then queue
  // whatever result it closes. Valid stays high on return so that a back-to-back
  // character needs only one assignment in that time step.
  task automatic send_char(input logic [7:0] c, input logic st,
                           input bit typed, input int_result_t typed_res);
    int          gap;
    bit          done;
    int_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    string_start <= st;
    do @(posedge clk); while (in_stall);
    predict_char(c, st, done, res);
    if (typed) begin
      expected_results.push_back(typed_res);
    end else if (done) begin
      expected_results.push_back(res);
    end
  endtask

  // Drop valid and wait until every queued result has come back, then give characters
  // that close no string time to leave the pipeline.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_base_mode(input logic [5:0] m);
    drain_results();
    cfg_we    <= 1'b1;
    base_mode <= m;
    @(posedge clk);
    cfg_we       <= 1'b0;
    base_setting  = m;
  endtask

  task automatic add_char(input logic [5:0] m, input logic [7:0] c, input logic st);
    stim_row_t r;
    r      = '0;
    r.mode = m;
    r.ch   = c;
    r.st   = st;
    stim_rows.push_back(r);
  endtask

  // Closing character of a directed string, with its result written out by hand.
  task automatic add_end(input logic [5:0] m, input logic [7:0] c, input logic [63:0] v,
                         input logic [15:0] off, input logic [5:0] b);
    stim_row_t r;
    r            = '0;
    r.mode       = m;
    r.ch         = c;
    r.typed      = 1'b1;
    r.res.value  = v;
    r.res.offset = off;
    r.res.base   = b;
    stim_rows.push_back(r);
  endtask

  // One random string, mostly well formed: blanks, sign, prefix, digits of the active base
  // and a terminator. The rest is stray bytes outside a string or random garbage.
  // Returns how many characters count toward the phase.
  task automatic send_random_string(output int counted);
    logic [7:0] text[$];
    int         kind, sel, n_digits, eff, lim, v;
    bit         hex_pfx, oct_pfx;
    counted = 0;
    if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // stray bytes: ignored when no string is open
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    end else if (kind < 14) begin
      // garbage with random string starts
      n_digits = $urandom_range(1, 4);
      repeat (n_digits) begin
        send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      counted = n_digits;
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) text.push_back(BLANKS[$urandom_range(0, 3)]);
      end
      case ($urandom_range(0, 3))
        0: text.push_back(CH_MINUS);
        1: text.push_back(CH_PLUS);
        default: ;
      endcase
      hex_pfx = (base_setting == BASE_DETECT || base_setting == BASE_HEX)
                && $urandom_range(0, 2) == 0;
      oct_pfx = !hex_pfx && base_setting == BASE_DETECT && $urandom_range(0, 3) == 0;
      if (hex_pfx) begin
        text.push_back(CH_0);
        text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      end
      if (oct_pfx) text.push_back(CH_0);
      if (base_setting == BASE_DETECT) begin
        eff = hex_pfx ? 16 : (oct_pfx ? 8 : 10);
      end else begin
        eff = int'(base_setting);
      end
      lim = (eff > 36) ? 36 : eff;
      // mostly short numbers; some long enough to wrap the 64-bit accumulator
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        n_digits = 0;
      end else if (sel < 3) begin
        n_digits = $urandom_range(12, 25);
      end else begin
        n_digits = $urandom_range(1, 6);
      end
      repeat (n_digits) begin
        v = $urandom_range(0, lim - 1);
        if (v < 10) begin
          text.push_back(8'(CH_0 + v));
        end else begin
          text.push_back(8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + v - 10));
        end
      end
      // leave some strings open so that the next start abandons them
      sel = $urandom_range(0, 9);
      if (sel >= 1 && sel <= 5) begin
        text.push_back(CH_NUL);
      end else if (sel > 5) begin
        text.push_back(8'($urandom_range(0, 255)));
      end
      foreach (text[i]) send_char(text[i], i == 0, 1'b0, '0);
      counted = text.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase_items, counted;
    bit hold_sent;

    // After reset the base is 10; the first row is a byte with no string open.
    add_char(BASE_DEC, "q", 1'b0);
    add_char(BASE_DEC, CH_TAB, 1'b1);
    add_char(BASE_DEC, CH_MINUS, 1'b0);
    add_char(BASE_DEC, "7", 1'b0);
    add_end (BASE_DEC, CH_NUL, 64'hFFFF_FFFF_FFFF_FFF9, 16'd3, BASE_DEC);
    // restart in mid-string, then a sign with no digits behind it
    add_char(BASE_DEC, "5", 1'b1);
    add_char(BASE_DEC, CH_PLUS, 1'b1);
    add_end (BASE_DEC, "Z", 64'd0, 16'd1, BASE_DEC);
    // detect mode: hex prefix with no digits, then a lone zero switching to octal
    add_char(BASE_DETECT, CH_0, 1'b1);
    add_char(BASE_DETECT, CH_LX, 1'b0);
    add_end (BASE_DETECT, "g", 64'd0, 16'd2, BASE_HEX);
    add_char(BASE_DETECT, CH_0, 1'b1);
    add_char(BASE_DETECT, "7", 1'b0);
    add_end (BASE_DETECT, "8", 64'd7, 16'd2, BASE_OCT);
    // base 16 skips its 0X prefix; letters of both cases
    add_char(BASE_HEX, CH_0, 1'b1);
    add_char(BASE_HEX, CH_UX, 1'b0);
    add_char(BASE_HEX, "f", 1'b0);
    add_char(BASE_HEX, "F", 1'b0);
    add_end (BASE_HEX, CH_NUL, 64'd255, 16'd4, BASE_HEX);
    // base 1 knows only the digit 0
    add_char(6'd1, CH_0, 1'b1);
    add_end (6'd1, "1", 64'd0, 16'd1, 6'd1);
    // base 36, closed by the top byte value, which is never a digit
    add_char(6'd36, "z", 1'b1);
    add_end (6'd36, 8'hFF, 64'd35, 16'd1, 6'd36);
    // largest base: all letters valid, punctuation still stops
    add_char(6'd63, "Z", 1'b1);
    add_end (6'd63, CH_MINUS, 64'd35, 16'd1, 6'd63);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].mode != base_setting) set_base_mode(stim_rows[i].mode);
      send_char(stim_rows[i].ch, stim_rows[i].st, stim_rows[i].typed, stim_rows[i].res);
    end

    // Random strings, one base setting per phase; the last setting is drawn at random.
    hold_sent = 1'b0;
    for (int p = 0; p < 10; p++) begin
      set_base_mode((p < 9) ? PHASE_MODES[p] : 6'($urandom_range(0, 63)));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_random_string(counted);
        phase_items += counted;
        // ask the receiver for its long hold-off while characters keep coming
        if (!hold_sent && phase_items >= 20) begin
          hold_sent    = 1'b1;
          hold_request = 1'b1;
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stall before each result, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        // hold long enough for the result register and input stage to fill up
        hold_request = 1'b0;
        out_stall   <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking and watchdog. Everything is sampled at the rising edge, before
  // any update of that edge takes effect.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    int_result_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: parsed_value %h stop_offset %0d base_used %0d",
                 parsed_value, stop_offset, base_used);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (parsed_value !== want.value) begin
            $error("parsed_value: expected %h, got %h", want.value, parsed_value);
            error_count++;
          end
          if (stop_offset !== want.offset) begin
            $error("stop_offset: expected %0d, got %0d", want.offset, stop_offset);
            error_count++;
          end
          if (base_used !== want.base) begin
            $error("base_used: expected %0d, got %0d", want.base, base_used);
            error_count++;
          end
        end
      end
    end
  end

endmodule
